/* hdl/mpe_pkg.sv */
// Package for the Mandelbrot pixel engine: word types, register map, constants, sequencer states.
`default_nettype none
package mpe_pkg;

	// Screen geometry; the row offset is taken about the middle row
	localparam int HEIGHT = 240;
	localparam logic [63:0] ROW_CENTER = 64'(HEIGHT / 2);

	// Q32.32 constants
	localparam logic [63:0] STEP_RECIP   = 64'h0000_0000_00CC_CCCD;  // about 1/320
	localparam logic [63:0] ESCAPE_BOUND = 64'h0000_0004_0000_0000;  // 4.0

	// Palette wraps from this value back to 1
	localparam logic [7:0] PAL_MAX = 8'd255;

	// Configuration port
	localparam int          APB_ADDR_W  = 5;
	localparam int          APB_DATA_W  = 64;
	localparam logic [15:0] LIMIT_RESET = 16'd128;

	typedef enum logic [1:0] {
		REG_CENTER_REAL = 2'd0,
		REG_CENTER_IMAG = 2'd1,
		REG_VIEW_SCALE  = 2'd2,
		REG_ITER_LIMIT  = 2'd3
	} reg_idx_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [63:0] center_real;
		logic [63:0] center_imag;
		logic [63:0] view_scale;
		logic [15:0] iteration_limit;
	} cfg_t;

	// Input word
	typedef struct packed {
		logic [8:0] pixel_column;
		logic [7:0] pixel_row;
	} pixel_t;

	// Output word
	typedef struct packed {
		logic [15:0] escape_count;
		logic [7:0]  palette_index;
	} result_t;

	// Shared multiplier request and response
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_XOFF,
		ST_YOFF,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CROSS,
		ST_UPDATE,
		ST_EMIT
	} seq_state_t;

endpackage
`default_nettype wire

/* hdl/mpe_pixel_if.sv */
// Pixel coordinate channel: valid/ready handshake carrying one pixel word.
`default_nettype none
interface mpe_pixel_if import mpe_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/mpe_result_if.sv */
// Result channel: valid/ready handshake carrying one escape count word.
`default_nettype none
interface mpe_result_if import mpe_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/mpe_cfg.sv */
// APB register file holding the view and iteration limit.
`default_nettype none
module mpe_cfg import mpe_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [63:0] center_real_q;
	logic [63:0] center_imag_q;
	logic [63:0] view_scale_q;
	logic [15:0] iter_limit_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[4:3]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_real_q <= '0;
			center_imag_q <= '0;
			view_scale_q  <= '0;
			iter_limit_q  <= LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_REAL: center_real_q <= pwdata;
				REG_CENTER_IMAG: center_imag_q <= pwdata;
				REG_VIEW_SCALE:  view_scale_q  <= pwdata;
				REG_ITER_LIMIT:  iter_limit_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_CENTER_REAL: prdata = center_real_q;
			REG_CENTER_IMAG: prdata = center_imag_q;
			REG_VIEW_SCALE:  prdata = view_scale_q;
			REG_ITER_LIMIT:  prdata = {48'd0, iter_limit_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.center_real     = center_real_q;
	assign cfg.center_imag     = center_imag_q;
	assign cfg.view_scale      = view_scale_q;
	assign cfg.iteration_limit = iter_limit_q;

endmodule
`default_nettype wire

/* hdl/mpe_mul.sv */
// Shared 64x64 signed multiplier: one 33x33 partial product a cycle, accumulated to 128 bits.
`default_nettype none
module mpe_mul import mpe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  mul_req_t      req,
	output mul_rsp_t      rsp
);

	logic [63:0]         a_q;
	logic [63:0]         b_q;
	logic                issue_q;
	logic [1:0]          cnt_q;
	logic signed [32:0]  op_a;
	logic signed [32:0]  op_b;
	logic signed [65:0]  pp;
	logic signed [65:0]  pp_s1;
	logic [1:0]          sel_s1;
	logic                vld_s1;
	logic                last_s1;
	logic [127:0]        pp_ext;
	logic [127:0]        acc_q;
	logic                done_q;

	// Halves: low half zero extended, high half sign extended
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = $signed({1'b0, a_q[31:0]});
				op_b = $signed({1'b0, b_q[31:0]});
			end
			2'd1: begin
				op_a = $signed({1'b0, a_q[31:0]});
				op_b = $signed({b_q[63], b_q[63:32]});
			end
			2'd2: begin
				op_a = $signed({a_q[63], a_q[63:32]});
				op_b = $signed({1'b0, b_q[31:0]});
			end
			default: begin
				op_a = $signed({a_q[63], a_q[63:32]});
				op_b = $signed({b_q[63], b_q[63:32]});
			end
		endcase
	end

	assign pp = op_a * op_b;

	// Align the registered partial product by its weight
	always_comb begin
		case (sel_s1)
			2'd0:    pp_ext = {{62{pp_s1[65]}}, pp_s1};
			2'd1,
			2'd2:    pp_ext = {{30{pp_s1[65]}}, pp_s1, 32'd0};
			default: pp_ext = {pp_s1[63:0], 64'd0};
		endcase
	end

	// Issue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (req.start) begin
				issue_q <= 1'b1;
				cnt_q   <= '0;
			end else if (issue_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					issue_q <= 1'b0;
			end
			vld_s1  <= issue_q;
			last_s1 <= issue_q && (cnt_q == 2'd3);
			done_q  <= vld_s1 && last_s1;
		end
	end

	// Operands, partial product stage, accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
		pp_s1  <= pp;
		sel_s1 <= cnt_q;
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule
`default_nettype wire

/* hdl/mpe_seq.sv */
// Sequencer and datapath: pixel point setup, z iteration and result register.
`default_nettype none
module mpe_seq import mpe_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  cfg_t           cfg,
	mpe_pixel_if.sink      pixel,
	mpe_result_if.source   result,
	output mul_req_t       mul_req,
	input  mul_rsp_t       mul_rsp
);

	seq_state_t  state_q;
	seq_state_t  state_d;
	logic        issued_q;
	logic [8:0]  col_q;
	logic [7:0]  row_q;
	logic [63:0] start_q;
	logic [63:0] step_q;
	logic [63:0] cre_q;
	logic [63:0] cim_q;
	logic [63:0] zre_q;
	logic [63:0] zim_q;
	logic [63:0] sqre_q;
	logic [63:0] sqim_q;
	logic [63:0] cross_q;
	logic [15:0] n_q;
	logic [7:0]  pal_q;
	logic [15:0] cnt_fin_q;
	logic [7:0]  pal_fin_q;
	logic        res_vld_q;
	result_t     res_q;

	logic        mul_state;
	logic        out_load;
	logic [63:0] prod_mid;
	logic [63:0] prod_low;
	logic [63:0] mag_sum;
	logic        escaped;
	logic [15:0] n_next;
	logic        last_iter;

	assign prod_mid  = mul_rsp.prod[95:32];
	assign prod_low  = mul_rsp.prod[63:0];
	assign mag_sum   = sqre_q + sqim_q;
	assign escaped   = $signed(mag_sum) > $signed(ESCAPE_BOUND);
	assign n_next    = n_q + 16'd1;
	assign last_iter = (n_next == cfg.iteration_limit);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (pixel.valid) state_d = ST_STEP;
			ST_STEP:   if (mul_rsp.done) state_d = ST_XOFF;
			ST_XOFF:   if (mul_rsp.done) state_d = ST_YOFF;
			ST_YOFF: begin
				if (mul_rsp.done)
					state_d = (cfg.iteration_limit == 16'd0) ? ST_EMIT : ST_SQ_RE;
			end
			ST_SQ_RE:  if (mul_rsp.done) state_d = ST_SQ_IM;
			ST_SQ_IM:  if (mul_rsp.done) state_d = ST_CROSS;
			ST_CROSS:  if (mul_rsp.done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = (escaped || last_iter) ? ST_EMIT : ST_SQ_RE;
			ST_EMIT:   if (!res_vld_q || result.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshakes and multiplier operand select
	always_comb begin
		pixel.ready = (state_q == ST_IDLE);
		out_load    = (state_q == ST_EMIT) && (!res_vld_q || result.ready);
		mul_state   = 1'b1;
		mul_req.a   = '0;
		mul_req.b   = '0;
		case (state_q)
			ST_STEP: begin
				mul_req.a = cfg.view_scale;
				mul_req.b = STEP_RECIP;
			end
			ST_XOFF: begin
				mul_req.a = step_q;
				mul_req.b = {55'd0, col_q};
			end
			ST_YOFF: begin
				mul_req.a = step_q;
				mul_req.b = ROW_CENTER - {56'd0, row_q};
			end
			ST_SQ_RE: begin
				mul_req.a = zre_q;
				mul_req.b = zre_q;
			end
			ST_SQ_IM: begin
				mul_req.a = zim_q;
				mul_req.b = zim_q;
			end
			ST_CROSS: begin
				mul_req.a = zre_q;
				mul_req.b = zim_q;
			end
			default: mul_state = 1'b0;
		endcase
		mul_req.start = mul_state && !issued_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issued_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start)
				issued_q <= 1'b1;
			else if (mul_rsp.done)
				issued_q <= 1'b0;
			if (out_load)
				res_vld_q <= 1'b1;
			else if (result.ready)
				res_vld_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pixel.valid) begin
					col_q   <= pixel.data.pixel_column;
					row_q   <= pixel.data.pixel_row;
					// half the scale is an arithmetic shift
					start_q <= cfg.center_real - {cfg.view_scale[63], cfg.view_scale[63:1]};
					zre_q   <= '0;
					zim_q   <= '0;
					n_q     <= '0;
					pal_q   <= 8'd1;
				end
			end
			ST_STEP:  if (mul_rsp.done) step_q <= prod_mid;
			ST_XOFF:  if (mul_rsp.done) cre_q <= start_q + prod_low;
			ST_YOFF: begin
				if (mul_rsp.done) begin
					cim_q     <= cfg.center_imag - prod_low;
					cnt_fin_q <= '0;
					pal_fin_q <= '0;
				end
			end
			ST_SQ_RE: if (mul_rsp.done) sqre_q <= prod_mid;
			ST_SQ_IM: if (mul_rsp.done) sqim_q <= prod_mid;
			ST_CROSS: if (mul_rsp.done) cross_q <= prod_mid;
			ST_UPDATE: begin
				zre_q <= sqre_q - sqim_q + cre_q;
				zim_q <= cross_q + cross_q + cim_q;
				n_q   <= n_next;
				pal_q <= (pal_q == PAL_MAX) ? 8'd1 : pal_q + 8'd1;
				if (escaped) begin
					cnt_fin_q <= n_next;
					pal_fin_q <= pal_q;
				end else begin
					cnt_fin_q <= '0;
					pal_fin_q <= '0;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			res_q.escape_count  <= cnt_fin_q;
			res_q.palette_index <= pal_fin_q;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;

endmodule
`default_nettype wire

/* hdl/mandelbrot_pixel_engine_top.sv */
// Top level of the Mandelbrot pixel engine: register file, shared multiplier, sequencer.
//
//   port     dir  handshake        word
//   pixel    in   valid/ready      pixel_column[8:0], pixel_row[7:0]
//   result   out  valid/ready      escape_count[15:0], palette_index[7:0]
//   apb      in   psel/penable     64-bit registers at byte address 8*i
//
// The time per pixel grows with the iterations run, which end at the limit or on escape.
// Every product goes through the single 33x33 multiplier in four partial products;
// an iteration needs three products and the update state.
// pixel.ready is high only while the sequencer is idle; a finished word waits in the
// output register so the next pixel can start; a stalled result holds the next one.
// Reset is asynchronous and returns the control state and the configuration registers
// to their reset values; the datapath registers are not reset.
`default_nettype none
module mandelbrot_pixel_engine_top import mpe_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	mpe_pixel_if.sink                  pixel,
	mpe_result_if.source               result
);

	cfg_t     cfg;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	mpe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mpe_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pixel   (pixel),
		.result  (result),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp)
	);

endmodule
`default_nettype wire
